// ===== design/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg
// Shared widths, operation and status codes, and register indexes for the
// chunk receipt scoreboard.
// ----------------------------------------------------------------------------
package crs_pkg;

	localparam int OP_W       = 2;
	localparam int CN_W       = 12;
	localparam int CNT_W      = 13;
	localparam int BYTE_W     = 29;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 29;

	localparam int MAX_CHUNKS_DEF  = 4096;
	localparam int CHUNK_BYTES_DEF = 65536;

	localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_TOTAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_BYTES  = 1'd1;

	localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

endpackage

// ===== design/crs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// crs_cfg_if
// Register write channel: one word carries a register index and its data.
// ----------------------------------------------------------------------------
interface crs_cfg_if;
	import crs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/crs_item_if.sv =====
// ----------------------------------------------------------------------------
// crs_item_if
// Operation channel: one word per scoreboard operation.
// ----------------------------------------------------------------------------
interface crs_item_if;
	import crs_pkg::*;

	logic            valid;
	logic            ready;
	logic [OP_W-1:0] operation;
	logic [CN_W-1:0] chunk_number;

	modport source (output valid, output operation, output chunk_number, input ready);
	modport sink (input valid, input operation, input chunk_number, output ready);
endinterface

// ===== design/crs_result_if.sv =====
// ----------------------------------------------------------------------------
// crs_result_if
// Result channel: one word per operation with counts and search outcome.
// ----------------------------------------------------------------------------
interface crs_result_if;
	import crs_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  completed_count;
	logic [BYTE_W-1:0] bytes_done;
	logic              all_done;
	logic              missing_found;
	logic [CN_W-1:0]   first_missing;

	modport source (
		output valid, output status, output completed_count, output bytes_done,
		output all_done, output missing_found, output first_missing, input ready
	);
	modport sink (
		input valid, input status, input completed_count, input bytes_done,
		input all_done, input missing_found, input first_missing, output ready
	);
endinterface

// ===== design/crs_ram.sv =====
// ----------------------------------------------------------------------------
// crs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/crs_rem.sv =====
// ----------------------------------------------------------------------------
// crs_rem
// Last chunk length: file size modulo the chunk size, or a full chunk when
// the remainder is zero. Reciprocal multiplication in order: quotient
// estimate, remainder estimate, then one correcting subtraction.
// ----------------------------------------------------------------------------
module crs_rem #(
	parameter int DIVISOR = crs_pkg::CHUNK_BYTES_DEF,
	localparam int LEN_W = $clog2(DIVISOR + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [crs_pkg::BYTE_W-1:0] dividend,
	output logic                      busy,
	output logic [LEN_W-1:0]          len
);
	import crs_pkg::*;

	localparam int SH  = BYTE_W + LEN_W;
	localparam int MW  = BYTE_W + 2;
	localparam int PRW = BYTE_W + MW;
	localparam int QDW = BYTE_W + LEN_W;
	localparam longint unsigned RECIP = (64'd1 << SH) / 64'(DIVISOR);
	localparam logic [MW-1:0] MV = MW'(RECIP);
	localparam logic [LEN_W:0] DV = (LEN_W + 1)'(DIVISOR);

	logic              busy_q;
	logic [1:0]        cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] div_q;
	logic [BYTE_W-1:0] quo_q;
	logic [LEN_W:0]    rem_q;
	logic [PRW-1:0]    prod;
	logic [QDW-1:0]    qd;
	logic [BYTE_W-1:0] rem_full;
	logic [LEN_W:0]    rem_fix;

	// quotient estimate is low by at most one, so the remainder is below 2*DIVISOR
	assign prod     = PRW'(div_q) * PRW'(MV);
	assign qd       = QDW'(quo_q) * QDW'(DIVISOR);
	assign rem_full = div_q - qd[BYTE_W-1:0];
	assign rem_fix  = (rem_q >= DV) ? rem_q - DV : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			len_q  <= LEN_W'(DIVISOR);
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 2'd2;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 2'd1;
			if (cnt_q == 2'd0) begin
				busy_q <= 1'b0;
				len_q  <= (rem_fix == '0) ? LEN_W'(DIVISOR) : rem_fix[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
		end else if (busy_q) begin
			quo_q <= BYTE_W'(prod >> SH);
			rem_q <= (LEN_W + 1)'(rem_full);
		end
	end

	assign busy = busy_q;
	assign len  = len_q;
endmodule

// ===== design/chunk_receipt_scoreboard.sv =====
// ----------------------------------------------------------------------------
// chunk_receipt_scoreboard
// Received-chunk bitmap with completed chunk and byte counts, completion flag
// and lowest missing chunk search.
//
//   port    role  word
//   cfg     sink  register index, data
//   item    sink  operation, chunk_number
//   result  src   status, counts, all_done, missing_found, first_missing
//
// Mark runs a bitmap word read, write back, word search read and bit
// search; query and an out-of-range mark run the word search read and bit
// search only. Clear and fill sweep the bitmap RAM one word a cycle, then
// search. After reset a clearing pass runs before item is ready. A write
// of file_bytes holds cfg and item while the last chunk length is computed.
// A result waiting on result may hold the next item in its final state.
// ----------------------------------------------------------------------------
module chunk_receipt_scoreboard #(
	parameter int MAX_CHUNKS  = crs_pkg::MAX_CHUNKS_DEF,
	parameter int CHUNK_BYTES = crs_pkg::CHUNK_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	crs_cfg_if.sink      cfg,
	crs_item_if.sink     item,
	crs_result_if.source result
);
	import crs_pkg::*;

	localparam int BM_WORDS = (MAX_CHUNKS + 63) / 64;
	localparam int WA_W     = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
	localparam int IDX_W    = WA_W + 6;
	localparam int CB_W     = $clog2(CHUNK_BYTES + 1);
	localparam int TW       = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
	localparam int PW       = CNT_W + CB_W;
	localparam int SW       = ((PW > BYTE_W) ? PW : BYTE_W) + 1;
	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(BM_WORDS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_BYTES = 3'd2;
	localparam logic [2:0] ST_MARK  = 3'd3;
	localparam logic [2:0] ST_FREAD = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]          state_q;
	logic                sw_fill_q;
	logic                sw_item_q;
	logic [WA_W-1:0]     swp_q;
	logic [CNT_W-1:0]    chunk_total_q;
	logic [CNT_W-1:0]    done_q;
	logic [BYTE_W-1:0]   bytes_q;
	logic [BM_WORDS-1:0] marks_q;
	logic [CN_W-1:0]     cn_q;
	logic [STAT_W-1:0]   status_q;
	logic [PW-1:0]       prod_q;
	logic [WA_W-1:0]     fw_q;
	logic                fany_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [BYTE_W-1:0] out_bytes_q;
	logic              out_all_q;
	logic              out_found_q;
	logic [CN_W-1:0]   out_first_q;

	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  tot_m1;
	logic              len_busy;
	logic [CB_W-1:0]   last_len;
	logic              item_acc;
	logic              cfg_acc;
	logic              ram_we;
	logic [WA_W-1:0]   ram_waddr;
	logic [63:0]       ram_wdata;
	logic [WA_W-1:0]   ram_raddr;
	logic [63:0]       ram_rdata;
	logic [WA_W-1:0]   cn_word;
	logic [WA_W-1:0]   w_sel;
	logic              any_sel;
	logic [TW-1:0]     lo;
	logic [TW-1:0]     tt;
	logic [TW-1:0]     diff;
	logic [63:0]       fill_word;
	logic [63:0]       mark_bit;
	logic [63:0]       mark_word;
	logic              mark_hit;
	logic [CB_W-1:0]   len_mark;
	logic [BYTE_W:0]   sum_mark;
	logic [BYTE_W-1:0] bytes_mark;
	logic [SW-1:0]     sum_fill;
	logic [BYTE_W-1:0] bytes_fill;
	logic [5:0]        zb;
	logic [IDX_W-1:0]  idx;
	logic              found;
	logic              fin_go;

	assign total  = (32'(chunk_total_q) > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : chunk_total_q;
	assign tot_m1 = total - CNT_W'(1);

	assign cfg.ready  = !len_busy;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign item.ready = (state_q == ST_IDLE) && !len_busy;
	assign item_acc   = item.valid && item.ready;

	crs_rem #(
		.DIVISOR (CHUNK_BYTES)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_acc && (cfg.index == REG_FILE_BYTES)),
		.dividend (cfg.data),
		.busy     (len_busy),
		.len      (last_len)
	);

	// fill pattern of the word under the sweep pointer
	always_comb begin
		lo   = TW'({swp_q, 6'd0});
		tt   = TW'(total);
		diff = tt - lo;
		if (tt >= lo + TW'(64)) begin
			fill_word = '1;
		end else if (tt <= lo) begin
			fill_word = '0;
		end else begin
			fill_word = ~({64{1'b1}} << diff[5:0]);
		end
	end

	assign cn_word   = WA_W'(cn_q[CN_W-1:6]);
	assign mark_bit  = 64'(1) << cn_q[5:0];
	assign mark_word = ram_rdata | mark_bit;
	assign mark_hit  = |(ram_rdata & mark_bit);
	assign len_mark  = (CNT_W'(cn_q) == tot_m1) ? last_len : CB_W'(CHUNK_BYTES);
	assign sum_mark  = (BYTE_W + 1)'(bytes_q) + (BYTE_W + 1)'(len_mark);
	assign bytes_mark = (sum_mark > (BYTE_W + 1)'(BYTE_MAX)) ? BYTE_MAX
		: sum_mark[BYTE_W-1:0];
	assign sum_fill  = SW'(prod_q) + SW'(last_len);
	assign bytes_fill = (total == '0) ? '0
		: (sum_fill > SW'(BYTE_MAX)) ? BYTE_MAX : sum_fill[BYTE_W-1:0];

	// first word not marked full
	always_comb begin
		w_sel   = '0;
		any_sel = 1'b0;
		for (int i = BM_WORDS - 1; i >= 0; i--) begin
			if (!marks_q[i]) begin
				w_sel   = WA_W'(i);
				any_sel = 1'b1;
			end
		end
	end

	// first zero bit of that word
	always_comb begin
		zb = 6'd63;
		for (int i = 63; i >= 0; i--) begin
			if (!ram_rdata[i]) begin
				zb = 6'(i);
			end
		end
	end

	assign idx    = {fw_q, zb};
	assign found  = fany_q && (TW'(idx) < TW'(total));
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	assign ram_we    = (state_q == ST_SWEEP) || ((state_q == ST_MARK) && !mark_hit);
	assign ram_waddr = (state_q == ST_SWEEP) ? swp_q : cn_word;
	assign ram_wdata = (state_q == ST_SWEEP) ? (sw_fill_q ? fill_word : '0) : mark_word;
	assign ram_raddr = (state_q == ST_IDLE) ? WA_W'(item.chunk_number[CN_W-1:6]) : w_sel;

	crs_ram #(
		.WIDTH (64),
		.DEPTH (BM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_total_q <= '0;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_CHUNK_TOTAL: chunk_total_q <= cfg.data[CNT_W-1:0];
				REG_FILE_BYTES:  chunk_total_q <= chunk_total_q;
				default:         chunk_total_q <= chunk_total_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			sw_fill_q <= 1'b0;
			sw_item_q <= 1'b0;
			swp_q     <= '0;
			done_q    <= '0;
			bytes_q   <= '0;
			marks_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						unique case (item.operation)
							OP_QUERY: state_q <= ST_FREAD;
							OP_MARK: begin
								if (CNT_W'(item.chunk_number) >= total) begin
									state_q <= ST_FREAD;
								end else begin
									state_q <= ST_MARK;
								end
							end
							OP_CLEAR: begin
								done_q    <= '0;
								bytes_q   <= '0;
								sw_fill_q <= 1'b0;
								sw_item_q <= 1'b1;
								swp_q     <= '0;
								state_q   <= ST_SWEEP;
							end
							OP_FILL: begin
								done_q    <= total;
								sw_fill_q <= 1'b1;
								sw_item_q <= 1'b1;
								swp_q     <= '0;
								state_q   <= ST_SWEEP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SWEEP: begin
					marks_q[swp_q] <= sw_fill_q && (fill_word == '1);
					swp_q <= swp_q + WA_W'(1);
					if (swp_q == LAST_WORD) begin
						if (!sw_item_q) begin
							state_q <= ST_IDLE;
						end else if (sw_fill_q) begin
							state_q <= ST_BYTES;
						end else begin
							state_q <= ST_FREAD;
						end
					end
				end
				ST_BYTES: begin
					bytes_q <= bytes_fill;
					state_q <= ST_FREAD;
				end
				ST_MARK: begin
					if (!mark_hit) begin
						marks_q[cn_word] <= (mark_word == '1);
						done_q  <= done_q + CNT_W'(1);
						bytes_q <= bytes_mark;
					end
					state_q <= ST_FREAD;
				end
				ST_FREAD: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(tot_m1) * PW'(CHUNK_BYTES);
		if (item_acc) begin
			cn_q <= item.chunk_number;
			if ((item.operation == OP_MARK) && (CNT_W'(item.chunk_number) >= total)) begin
				status_q <= STAT_RANGE;
			end else begin
				status_q <= STAT_DONE;
			end
		end else if ((state_q == ST_MARK) && mark_hit) begin
			status_q <= STAT_DUP;
		end
		if (state_q == ST_FREAD) begin
			fw_q   <= w_sel;
			fany_q <= any_sel;
		end
		if (fin_go) begin
			out_status_q <= status_q;
			out_count_q  <= done_q;
			out_bytes_q  <= bytes_q;
			out_all_q    <= (done_q >= total);
			out_found_q  <= found;
			out_first_q  <= found ? CN_W'(idx) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = out_status_q;
	assign result.completed_count = out_count_q;
	assign result.bytes_done      = out_bytes_q;
	assign result.all_done        = out_all_q;
	assign result.missing_found   = out_found_q;
	assign result.first_missing   = out_first_q;
endmodule
